[hw/rtl/neighbor_ring_arbiter_top_assert.svh]
// ----------------------------------------------------------------------------
// neighbor ring arbiter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// They compile to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_RING_ARBITER_TOP_ASSERT_SVH
`define NEIGHBOR_RING_ARBITER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define NRA_ASSERT_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("neighbor ring arbiter check failed");
// next-cycle implication
`define NRA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("neighbor ring arbiter check failed");
`else
`define NRA_ASSERT_IMPLY(name, pre, post)
`define NRA_ASSERT_NEXT(name, pre, post)
`endif
`endif

[hw/rtl/nra_pkg.sv]
// ----------------------------------------------------------------------------
// nra_pkg
// Types, codes and helper functions shared by the neighbor ring arbiter.
// ----------------------------------------------------------------------------
package nra_pkg;

  // default ring capacity
  localparam int NRA_MAX_CLIENTS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  // scheduler modes
  localparam logic SCHED_FIFO = 1'b0;
  localparam logic SCHED_EDF  = 1'b1;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // number of client table positions kept per item; a request reads three, a release four
  localparam int SLOT_NUM = 5;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_GRANT = 2'd2
  } status_t;

  // table positions around the client being handled
  typedef enum logic [2:0] {
    SL_SELF = 3'd0,
    SL_L1   = 3'd1,
    SL_L2   = 3'd2,
    SL_R1   = 3'd3,
    SL_R2   = 3'd4
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_EV_REQ,
    S_EV_L,
    S_EV_R,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  client_index;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [3:0] granted_client;
    logic       last;
  } out_item_t;

  // one client table entry
  typedef struct packed {
    status_t     st;
    logic [31:0] rq;
    logic [31:0] dl;
  } entry_t;

  // up to two results handed to the result queue at once
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } res_push_t;

  // priority key of an entry
  function automatic logic [31:0] key_of(input entry_t e, input logic edf);
    return (edf == SCHED_EDF) ? e.dl : e.rq;
  endfunction

  // waiting neighbor with strictly smaller key wins
  function automatic logic beats(input entry_t j, input logic [31:0] key_c, input logic edf);
    return (j.st == ST_WAIT) && (key_of(j, edf) < key_c);
  endfunction

  // table position fetched at each read step
  function automatic slot_t rd_slot_of(input op_t op, input logic [1:0] step);
    slot_t s;
    s = SL_SELF;
    if (op == OP_REQUEST) begin
      unique case (step)
        2'd0:    s = SL_SELF;
        2'd1:    s = SL_L1;
        default: s = SL_R1;
      endcase
    end else begin
      unique case (step)
        2'd0:    s = SL_L1;
        2'd1:    s = SL_L2;
        2'd2:    s = SL_R1;
        default: s = SL_R2;
      endcase
    end
    return s;
  endfunction

  // final read step of an operation
  function automatic logic [1:0] last_step(input op_t op);
    return (op == OP_REQUEST) ? 2'd2 : 2'd3;
  endfunction

endpackage

[hw/rtl/nra_ram.sv]
// ----------------------------------------------------------------------------
// nra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/nra_res_queue.sv]
// ----------------------------------------------------------------------------
// nra_res_queue
// Small result queue taking up to two grant beats per cycle and
// presenting one beat at a time on the result channel.
// ----------------------------------------------------------------------------
module nra_res_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nra_pkg::res_push_t              push,
  output logic [nra_pkg::RQ_CNT_W-1:0]    free,
  output logic                            out_valid,
  input  logic                            out_stall,
  output nra_pkg::out_item_t              out_data
);

  import nra_pkg::*;

  out_item_t             mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_ptr_r;
  logic [RQ_PTR_W-1:0]   rd_ptr_r;
  logic [RQ_CNT_W-1:0]   cnt_r;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign free      = RQ_CNT_W'(RQ_DEPTH) - cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + RQ_PTR_W'(1)] <= push.item1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + RQ_PTR_W'(pop);
      cnt_r    <= cnt_r + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/nra_ctrl.sv]
// ----------------------------------------------------------------------------
// nra_ctrl
// Sequencer of the arbiter: gathers the neighbor entries of the client
// table one read a cycle, decides grants and writes the entries back.
// ----------------------------------------------------------------------------
`include "neighbor_ring_arbiter_top_assert.svh"

module nra_ctrl #(
  parameter int MAX_CLIENTS = nra_pkg::NRA_MAX_CLIENTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  nra_pkg::in_item_t                     in_data,
  input  logic                                  sched_mode,
  input  logic [$clog2(MAX_CLIENTS+1)-1:0]      ring_size,
  input  logic [31:0]                           deadline_offset,
  output logic                                  ram_we,
  output logic [$clog2(MAX_CLIENTS)-1:0]        ram_waddr,
  output nra_pkg::entry_t                       ram_wdata,
  output logic [$clog2(MAX_CLIENTS)-1:0]        ram_raddr,
  input  nra_pkg::entry_t                       ram_rdata,
  output nra_pkg::res_push_t                    push,
  input  logic [nra_pkg::RQ_CNT_W-1:0]          q_free
);

  import nra_pkg::*;

  localparam int CW = $clog2(MAX_CLIENTS);
  localparam int NW = $clog2(MAX_CLIENTS + 1);

  // ring neighbors
  function automatic logic [CW-1:0] left_of(input logic [CW-1:0] i, input logic [NW-1:0] n);
    logic [NW-1:0] nx;
    nx = NW'(i) + NW'(1);
    return (nx == n) ? '0 : CW'(nx);
  endfunction

  function automatic logic [CW-1:0] right_of(input logic [CW-1:0] i, input logic [NW-1:0] n);
    return (i == '0) ? CW'(n - NW'(1)) : (i - CW'(1));
  endfunction

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [CW-1:0]       idx_r;
  logic [31:0]         ts_r;
  logic [31:0]         dl_r;
  logic [CW-1:0]       slot_idx_r [SLOT_NUM];
  entry_t              slot_r [SLOT_NUM];
  logic [1:0]          step_r;
  logic                cap_vld_r;
  slot_t               cap_slot_r;
  logic                vbit_r;
  logic [MAX_CLIENTS-1:0] valid_r;
  logic [1:0]          cnt_r;
  out_item_t           res0_r;
  out_item_t           res1_r;

  logic                in_acc;
  logic                in_range;
  logic [CW-1:0]       in_idx;
  logic [CW-1:0]       in_l1, in_r1;
  logic [32:0]         dl_sum;
  logic [31:0]         in_dl;
  slot_t               rd_slot;
  entry_t              cap_entry;
  logic [31:0]         own_key;
  logic                self_idle;
  logic                req_ok;
  logic                l_ok;
  logic                r_ok;

  // input decode
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (32'(in_data.client_index) < 32'(ring_size));
  assign in_idx   = CW'(in_data.client_index);
  assign in_l1    = left_of(in_idx, ring_size);
  assign in_r1    = right_of(in_idx, ring_size);
  assign dl_sum   = {1'b0, in_data.timestamp} + {1'b0, deadline_offset};
  assign in_dl    = dl_sum[32] ? '1 : dl_sum[31:0];

  // read sequencing
  assign rd_slot = rd_slot_of(op_r, step_r);

  always_comb begin
    cap_entry = ram_rdata;
    if (!vbit_r) begin
      cap_entry.st = ST_IDLE;
    end
  end

  // grant decisions
  assign own_key   = (sched_mode == SCHED_EDF) ? dl_r : ts_r;
  assign self_idle = (slot_r[SL_SELF].st == ST_IDLE);
  assign req_ok    = (slot_r[SL_L1].st != ST_GRANT) && (slot_r[SL_R1].st != ST_GRANT) &&
                     !beats(slot_r[SL_L1], own_key, sched_mode) &&
                     !beats(slot_r[SL_R1], own_key, sched_mode);
  assign l_ok      = (slot_r[SL_L1].st == ST_WAIT) && (slot_r[SL_L2].st != ST_GRANT) &&
                     !beats(slot_r[SL_L2], key_of(slot_r[SL_L1], sched_mode), sched_mode);
  assign r_ok      = (slot_r[SL_R1].st == ST_WAIT) && (slot_r[SL_R2].st != ST_GRANT) &&
                     !beats(slot_r[SL_R2], key_of(slot_r[SL_R1], sched_mode), sched_mode);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = '{st: ST_WAIT, rq: ts_r, dl: dl_r};
    ram_raddr   = slot_idx_r[rd_slot];
    push        = '0;
    push.item0  = res0_r;
    push.item1  = res1_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_range) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (step_r == last_step(op_r)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = (op_r == OP_REQUEST) ? S_EV_REQ : S_EV_L;
      end
      S_EV_REQ: begin
        ram_we    = self_idle;
        ram_waddr = idx_r;
        ram_wdata = '{st: (req_ok ? ST_GRANT : ST_WAIT), rq: ts_r, dl: dl_r};
        state_nxt = S_PUSH;
      end
      S_EV_L: begin
        ram_we    = l_ok;
        ram_waddr = slot_idx_r[SL_L1];
        ram_wdata = '{st: ST_GRANT, rq: slot_r[SL_L1].rq, dl: slot_r[SL_L1].dl};
        state_nxt = S_EV_R;
      end
      S_EV_R: begin
        ram_we    = r_ok;
        ram_waddr = slot_idx_r[SL_R1];
        ram_wdata = '{st: ST_GRANT, rq: slot_r[SL_R1].rq, dl: slot_r[SL_R1].dl};
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (q_free >= RQ_CNT_W'(cnt_r)) begin
          push.cnt  = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // item capture at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r                <= op_t'(in_data.mode);
      idx_r               <= in_idx;
      ts_r                <= in_data.timestamp;
      dl_r                <= in_dl;
      slot_idx_r[SL_SELF] <= in_idx;
      slot_idx_r[SL_L1]   <= in_l1;
      slot_idx_r[SL_L2]   <= left_of(in_l1, ring_size);
      slot_idx_r[SL_R1]   <= in_r1;
      slot_idx_r[SL_R2]   <= right_of(in_r1, ring_size);
    end
  end

  // read step counter and capture pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      cap_vld_r <= 1'b0;
    end else begin
      step_r    <= (state_r == S_READ) ? step_r + 2'd1 : 2'd0;
      cap_vld_r <= (state_r == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    cap_slot_r <= rd_slot;
    vbit_r     <= valid_r[ram_raddr];
  end

  // gathered entries, with a left grant mirrored into aliased positions
  always_ff @(posedge clk) begin
    if (cap_vld_r) begin
      slot_r[cap_slot_r] <= cap_entry;
    end else if ((state_r == S_EV_L) && l_ok) begin
      for (int s = 0; s < SLOT_NUM; s++) begin
        if (slot_idx_r[s] == slot_idx_r[SL_L1]) begin
          slot_r[s].st <= ST_GRANT;
        end
      end
    end
  end

  // per-client written flags; a clear flag reads as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (in_acc && in_range && (in_data.mode == OP_RELEASE)) begin
      valid_r[in_idx] <= 1'b0;
    end else if ((state_r == S_EV_REQ) && self_idle) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  // pending grant beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_EV_REQ: cnt_r <= {1'b0, self_idle && req_ok};
        S_EV_L:   cnt_r <= {1'b0, l_ok};
        S_EV_R: begin
          if (r_ok) begin
            cnt_r <= (cnt_r == 2'd1) ? 2'd2 : 2'd1;
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_EV_REQ: res0_r <= '{granted_client: 4'(idx_r), last: 1'b1};
      S_EV_L:   res0_r <= '{granted_client: 4'(slot_idx_r[SL_L1]), last: 1'b1};
      S_EV_R: begin
        if (r_ok) begin
          if (cnt_r == 2'd1) begin
            res0_r.last <= 1'b0;
            res1_r      <= '{granted_client: 4'(slot_idx_r[SL_R1]), last: 1'b1};
          end else begin
            res0_r <= '{granted_client: 4'(slot_idx_r[SL_R1]), last: 1'b1};
          end
        end
      end
      default: res0_r <= res0_r;
    endcase
  end

  // checks
  `NRA_ASSERT_IMPLY(a_wr_only_in_eval, ram_we, (state_r == S_EV_REQ) || (state_r == S_EV_L) || (state_r == S_EV_R))
  `NRA_ASSERT_IMPLY(a_no_double_grant, (state_r == S_EV_R) && r_ok && (cnt_r == 2'd1), slot_idx_r[SL_R1] != slot_idx_r[SL_L1])
  `NRA_ASSERT_NEXT(a_release_clears, in_acc && in_range && (in_data.mode == OP_RELEASE), !valid_r[idx_r])
  `NRA_ASSERT_NEXT(a_request_marks, (state_r == S_EV_REQ) && self_idle, valid_r[idx_r])

endmodule

[hw/rtl/neighbor_ring_arbiter_top.sv]
// Per item: a request reads three client table entries and a release four, one entry a cycle
// through the table's single read port; an index outside the ring is accepted and dropped. A new
// item is taken only in idle, once the grant beats of the last one have gone to the result queue.
// Reset is synchronous and active low: all clients read as idle at once through per-entry
// written flags, configuration returns to fifo mode, two clients and zero deadline offset.
// ----------------------------------------------------------------------------
// neighbor_ring_arbiter_top
// Ring arbiter granting shared neighbor resources in oldest-first or
// earliest-deadline-first order; holds the configuration registers.
// ----------------------------------------------------------------------------
module neighbor_ring_arbiter_top #(
  parameter int MAX_CLIENTS = nra_pkg::NRA_MAX_CLIENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nra_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nra_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [nra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nra_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import nra_pkg::*;

  localparam int CW = $clog2(MAX_CLIENTS);
  localparam int NW = $clog2(MAX_CLIENTS + 1);

  logic              cfg_mode_r;
  logic [4:0]        cfg_count_r;
  logic [31:0]       cfg_offset_r;
  logic [NW-1:0]     ring_size;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [CW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  res_push_t         push;
  logic [RQ_CNT_W-1:0] q_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= SCHED_FIFO;
      cfg_count_r  <= 5'd2;
      cfg_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_mode_r   <= cfg_wdata[0];
        CFG_COUNT:  cfg_count_r  <= cfg_wdata[4:0];
        CFG_OFFSET: cfg_offset_r <= cfg_wdata[31:0];
        default:    cfg_mode_r   <= cfg_mode_r;
      endcase
    end
  end

  // effective ring size, clamped to the supported range
  always_comb begin
    if (cfg_count_r < 5'd2) begin
      ring_size = NW'(2);
    end else if (32'(cfg_count_r) > 32'(MAX_CLIENTS)) begin
      ring_size = NW'(MAX_CLIENTS);
    end else begin
      ring_size = NW'(cfg_count_r);
    end
  end

  nra_ctrl #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .sched_mode      (cfg_mode_r),
    .ring_size       (ring_size),
    .deadline_offset (cfg_offset_r),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .push            (push),
    .q_free          (q_free)
  );

  // client table: status and both stamps per client
  nra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_CLIENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nra_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
